// ===== rtl/core/tlr_pkg.sv =====
// Shared types and constants for the thick line rasterizer.
package tlr_pkg;

  // Visible display area in pixels.
  localparam logic [8:0] DISPLAY_WIDTH  = 9'd128;
  localparam logic [8:0] DISPLAY_HEIGHT = 9'd128;

  // Input item opcodes.
  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } tlr_op_e;

  // Line set-up carried by a start item.
  typedef struct packed {
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic [3:0] pen_size;
    logic [3:0] pen_color;
  } tlr_line_cmd_t;

  // One pen position as produced by the walker.
  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
    logic [3:0] color;
    logic       write_enable;
    logic       last;
  } tlr_pixel_t;

endpackage

// ===== rtl/core/tlr_if.sv =====
// Handshake interfaces for the rasterizer command and pixel channels.
interface tlr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] x_start;
  logic [7:0] y_start;
  logic [7:0] x_end;
  logic [7:0] y_end;
  logic [3:0] pen_size;
  logic [3:0] pen_color;

  modport source (
    output valid, opcode, x_start, y_start, x_end, y_end, pen_size, pen_color,
    input  ready
  );
  modport sink (
    input  valid, opcode, x_start, y_start, x_end, y_end, pen_size, pen_color,
    output ready
  );
endinterface

interface tlr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [3:0] pixel_color;
  logic       write_enable;
  logic       last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, write_enable, last,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, write_enable, last,
    output ready
  );
endinterface

// ===== rtl/core/thick_line_rasterizer.sv =====
// A step item's pixel is in the output register in the cycle after it is accepted.
// Throughput: one item per cycle; a waiting pixel blocks the input until it is taken.
// Start items and steps while idle produce no pixel.
// Reset is asynchronous and active low; it leaves the walker idle and the output empty.
// Pen positions come from a single Bresenham/pen-scan update between state and output register.
module thick_line_rasterizer
  import tlr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tlr_in_if.sink     in_i,
  tlr_out_if.source  out_o
);

  logic          accept;
  logic          start_en, step_en;
  logic          walk_busy;
  tlr_line_cmd_t cmd;
  tlr_pixel_t    pixel;
  tlr_pixel_t    out_q;
  logic          out_valid_q, out_valid_d;

  // Input is taken whenever the output register is free or draining.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign start_en   = accept && (in_i.opcode == OP_START);
  assign step_en    = accept && (in_i.opcode == OP_STEP);

  assign cmd.x_start   = in_i.x_start;
  assign cmd.y_start   = in_i.y_start;
  assign cmd.x_end     = in_i.x_end;
  assign cmd.y_end     = in_i.y_end;
  assign cmd.pen_size  = in_i.pen_size;
  assign cmd.pen_color = in_i.pen_color;

  tlr_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_en),
    .step_i  (step_en),
    .cmd_i   (cmd),
    .busy_o  (walk_busy),
    .pixel_o (pixel)
  );

  // Output register valid: loaded by a step on a busy walker, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (step_en && walk_busy) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, no reset needed.
  always_ff @(posedge clk_i) begin
    if (step_en && walk_busy) begin
      out_q <= pixel;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_x      = out_q.x;
  assign out_o.pixel_y      = out_q.y;
  assign out_o.pixel_color  = out_q.color;
  assign out_o.write_enable = out_q.write_enable;
  assign out_o.last         = out_q.last;

`ifndef SYNTHESIS
  // A new pixel only follows an accepted step on a busy walker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_en && walk_busy))
    else $error("pixel without a step");

  // The final pen position of a line leaves the walker idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && walk_busy && pixel.last) |=> !walk_busy)
    else $error("walker busy after last pixel");

  // An empty output register never blocks the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty output");
`endif

endmodule

// ===== rtl/core/tlr_walker.sv =====
// Bresenham line walker with square pen scan, one pen position per step.
module tlr_walker
  import tlr_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          step_i,
  input  tlr_line_cmd_t cmd_i,
  output logic          busy_o,
  output tlr_pixel_t    pixel_o
);

  logic              busy_q, busy_d;
  logic [7:0]        point_x_q, point_x_d;
  logic [7:0]        point_y_q, point_y_d;
  logic [7:0]        target_x_q, target_x_d;
  logic [7:0]        target_y_q, target_y_d;
  logic [7:0]        delta_x_q, delta_x_d;
  logic signed [8:0] neg_delta_y_q, neg_delta_y_d;
  logic signed [9:0] error_q, error_d;
  logic [1:0]        dirs_q, dirs_d;
  logic [4:0]        pen_col_q, pen_col_d;
  logic [4:0]        pen_row_q, pen_row_d;
  logic [3:0]        pen_size_q, pen_size_d;
  logic [3:0]        pen_color_q, pen_color_d;

  logic              start_ok;
  logic [7:0]        abs_dx, abs_dy;
  logic [4:0]        side_last;
  logic signed [9:0] pos_x, pos_y;
  logic              pos_we;
  logic              row_wrap, pen_wrap;
  logic signed [10:0] e2;
  logic              x_move, y_move, fin_x, fin_y, line_done;
  logic signed [9:0] err_add_x, err_add_y;

  // A start is taken only if both endpoints lie on the display.
  assign start_ok = ({1'b0, cmd_i.x_start} < DISPLAY_WIDTH)  &&
                    ({1'b0, cmd_i.y_start} < DISPLAY_HEIGHT) &&
                    ({1'b0, cmd_i.x_end}   < DISPLAY_WIDTH)  &&
                    ({1'b0, cmd_i.y_end}   < DISPLAY_HEIGHT);
  assign abs_dx = (cmd_i.x_end >= cmd_i.x_start) ? cmd_i.x_end - cmd_i.x_start
                                                 : cmd_i.x_start - cmd_i.x_end;
  assign abs_dy = (cmd_i.y_end >= cmd_i.y_start) ? cmd_i.y_end - cmd_i.y_start
                                                 : cmd_i.y_start - cmd_i.y_end;

  // Current pen position, offset by minus the pen size in both axes.
  assign pos_x = $signed({2'b00, point_x_q}) + $signed({5'b0, pen_col_q})
               - $signed({6'b0, pen_size_q});
  assign pos_y = $signed({2'b00, point_y_q}) + $signed({5'b0, pen_row_q})
               - $signed({6'b0, pen_size_q});
  assign pos_we = !pos_x[9] && !pos_y[9] &&
                  (point_y_q >= {4'b0, pen_size_q}) &&
                  (pos_x[8:0] < DISPLAY_WIDTH) && (pos_y[8:0] < DISPLAY_HEIGHT);

  // Pen scan: rows inside columns; last index is 2*size-2.
  assign side_last = {pen_size_q, 1'b0} - 5'd2;
  assign row_wrap  = (pen_row_q == side_last);
  assign pen_wrap  = row_wrap && (pen_col_q == side_last);

  // Bresenham decisions on the doubled error term.
  assign e2        = {error_q[9], error_q} <<< 1;
  assign x_move    = e2 >= $signed({{2{neg_delta_y_q[8]}}, neg_delta_y_q});
  assign y_move    = e2 <= $signed({3'b000, delta_x_q});
  assign fin_x     = x_move && (point_x_q == target_x_q);
  assign fin_y     = !fin_x && y_move && (point_y_q == target_y_q);
  assign line_done = pen_wrap && (fin_x || fin_y);
  assign err_add_x = (x_move && !fin_x) ? {neg_delta_y_q[8], neg_delta_y_q} : 10'sd0;
  assign err_add_y = (y_move && !fin_x && !fin_y) ? $signed({2'b00, delta_x_q}) : 10'sd0;

  // Next-state selection for start and step items.
  always_comb begin
    busy_d        = busy_q;
    point_x_d     = point_x_q;
    point_y_d     = point_y_q;
    target_x_d    = target_x_q;
    target_y_d    = target_y_q;
    delta_x_d     = delta_x_q;
    neg_delta_y_d = neg_delta_y_q;
    error_d       = error_q;
    dirs_d        = dirs_q;
    pen_col_d     = pen_col_q;
    pen_row_d     = pen_row_q;
    pen_size_d    = pen_size_q;
    pen_color_d   = pen_color_q;
    if (start_i && start_ok) begin
      point_x_d     = cmd_i.x_start;
      point_y_d     = cmd_i.y_start;
      target_x_d    = cmd_i.x_end;
      target_y_d    = cmd_i.y_end;
      delta_x_d     = abs_dx;
      neg_delta_y_d = -$signed({1'b0, abs_dy});
      error_d       = $signed({2'b00, abs_dx}) - $signed({2'b00, abs_dy});
      dirs_d        = {!(cmd_i.y_start < cmd_i.y_end), !(cmd_i.x_start < cmd_i.x_end)};
      pen_col_d     = 5'd0;
      pen_row_d     = 5'd0;
      pen_size_d    = cmd_i.pen_size;
      pen_color_d   = cmd_i.pen_color;
      busy_d        = (cmd_i.pen_size != 4'd0);
    end else if (step_i && busy_q) begin
      if (!row_wrap) begin
        pen_row_d = pen_row_q + 5'd1;
      end else begin
        pen_row_d = 5'd0;
        if (!pen_wrap) begin
          pen_col_d = pen_col_q + 5'd1;
        end else begin
          pen_col_d = 5'd0;
          error_d   = error_q + err_add_x + err_add_y;
          if (x_move && !fin_x) begin
            point_x_d = dirs_q[0] ? point_x_q - 8'd1 : point_x_q + 8'd1;
          end
          if (y_move && !fin_x && !fin_y) begin
            point_y_d = dirs_q[1] ? point_y_q - 8'd1 : point_y_q + 8'd1;
          end
          if (fin_x || fin_y) begin
            busy_d = 1'b0;
          end
        end
      end
    end
  end

  // Walker state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      point_x_q     <= '0;
      point_y_q     <= '0;
      target_x_q    <= '0;
      target_y_q    <= '0;
      delta_x_q     <= '0;
      neg_delta_y_q <= '0;
      error_q       <= '0;
      dirs_q        <= '0;
      pen_col_q     <= '0;
      pen_row_q     <= '0;
      pen_size_q    <= '0;
      pen_color_q   <= '0;
    end else begin
      busy_q        <= busy_d;
      point_x_q     <= point_x_d;
      point_y_q     <= point_y_d;
      target_x_q    <= target_x_d;
      target_y_q    <= target_y_d;
      delta_x_q     <= delta_x_d;
      neg_delta_y_q <= neg_delta_y_d;
      error_q       <= error_d;
      dirs_q        <= dirs_d;
      pen_col_q     <= pen_col_d;
      pen_row_q     <= pen_row_d;
      pen_size_q    <= pen_size_d;
      pen_color_q   <= pen_color_d;
    end
  end

  // Pixel for the current step, taken from the state before it advances.
  assign busy_o               = busy_q;
  assign pixel_o.x            = pos_x[7:0];
  assign pixel_o.y            = pos_y[7:0];
  assign pixel_o.color        = pen_color_q;
  assign pixel_o.write_enable = pos_we;
  assign pixel_o.last         = line_done;

endmodule

// ===== sim/tb_thick_line_rasterizer.sv =====
// Self-checking testbench for the thick line rasterizer: directed table, then random line runs.
module tb_thick_line_rasterizer;
  import tlr_pkg::*;

  localparam int TotalItems  = 1350;
  localparam int QuietFrom   = TotalItems - 150;
  localparam int CycleLimit  = 200000;
  localparam int PrintLimit  = 30;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_SILENT,
    ROW_TYPED
  } row_check_e;

  typedef struct packed {
    tlr_op_e       op;
    tlr_line_cmd_t cmd;
  } raster_item_t;

  typedef struct packed {
    raster_item_t item;
    row_check_e   check;
    tlr_pixel_t   pix;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tlr_in_if  in_bus ();
  tlr_out_if out_bus ();

  thick_line_rasterizer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #2 clk_i = ~clk_i;

  // Line walker state as the block should hold it.
  bit                ln_busy;
  logic [7:0]        ln_x, ln_y, ln_tx, ln_ty, ln_dx;
  logic signed [8:0] ln_ndy;
  logic signed [9:0] ln_err;
  logic [1:0]        ln_dirs;
  logic [4:0]        ln_col, ln_row;
  logic [3:0]        ln_size, ln_color;

  tlr_pixel_t pending_pixels[$];
  stim_row_t  directed_rows[$];

  int  items_sent;
  int  starts_sent;
  int  pixels_checked;
  int  lines_done;
  int  error_count;
  int  cycle_count;
  bit  idle_allowed;

  // One line point forward; returns 1 when the line end has been drawn.
  function automatic bit advance_point();
    int e2, dxv, dyv;
    e2  = 2 * int'(ln_err);
    dxv = int'(ln_dx);
    dyv = int'(ln_ndy);
    if (e2 >= dyv) begin
      if (ln_x == ln_tx) return 1'b1;
      ln_err = 10'(int'(ln_err) + dyv);
      ln_x   = ln_dirs[0] ? ln_x - 8'd1 : ln_x + 8'd1;
    end
    if (e2 <= dxv) begin
      if (ln_y == ln_ty) return 1'b1;
      ln_err = 10'(int'(ln_err) + dxv);
      ln_y   = ln_dirs[1] ? ln_y - 8'd1 : ln_y + 8'd1;
    end
    return 1'b0;
  endfunction

  // Applies one accepted item to the walker state; returns 1 with the pixel it yields.
  function automatic bit next_pen_pixel(input raster_item_t it, output tlr_pixel_t px);
    int size, side, col, row, pxx, pyy, ady;
    bit fin, we;
    px = '0;
    if (it.op == OP_START) begin
      if (it.cmd.x_start >= DISPLAY_WIDTH || it.cmd.y_start >= DISPLAY_HEIGHT ||
          it.cmd.x_end >= DISPLAY_WIDTH || it.cmd.y_end >= DISPLAY_HEIGHT)
        return 1'b0;
      ln_x     = it.cmd.x_start;
      ln_y     = it.cmd.y_start;
      ln_tx    = it.cmd.x_end;
      ln_ty    = it.cmd.y_end;
      ln_dx    = (ln_tx >= ln_x) ? ln_tx - ln_x : ln_x - ln_tx;
      ady      = (ln_ty >= ln_y) ? int'(ln_ty) - int'(ln_y) : int'(ln_y) - int'(ln_ty);
      ln_ndy   = 9'(-ady);
      ln_err   = 10'(int'(ln_dx) - ady);
      ln_dirs  = {ln_y >= ln_ty, ln_x >= ln_tx};
      ln_col   = '0;
      ln_row   = '0;
      ln_size  = it.cmd.pen_size;
      ln_color = it.cmd.pen_color;
      ln_busy  = (it.cmd.pen_size != 4'd0);
      return 1'b0;
    end
    if (!ln_busy) return 1'b0;
    size = int'(ln_size);
    side = 2 * size - 1;
    col  = int'(ln_col);
    row  = int'(ln_row);
    pxx  = int'(ln_x) + col - size;
    pyy  = int'(ln_y) + row - size;
    we   = pxx >= 0 && int'(ln_y) >= size && pxx < int'(DISPLAY_WIDTH) &&
           pyy >= 0 && pyy < int'(DISPLAY_HEIGHT);
    fin  = 1'b0;
    // Column-major pen scan; the line point moves after the last pen column.
    if (row + 1 < side) begin
      row++;
    end else begin
      row = 0;
      if (col + 1 < side) begin
        col++;
      end else begin
        col = 0;
        fin = advance_point();
      end
    end
    ln_col = 5'(col);
    ln_row = 5'(row);
    if (fin) ln_busy = 1'b0;
    px.x            = 8'(pxx);
    px.y            = 8'(pyy);
    px.color        = ln_color;
    px.write_enable = we;
    px.last         = fin;
    return 1'b1;
  endfunction

  task automatic flag_error(input string what, input int got, input int want);
    error_count++;
    if (error_count <= PrintLimit)
      $display("mismatch at cycle %0d: %s, got %0d, expected %0d", cycle_count, what, got, want);
  endtask

  // Drives one item and waits until the block takes it.
  task automatic send_item(input raster_item_t it);
    if (idle_allowed && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.opcode    <= it.op;
    in_bus.x_start   <= it.cmd.x_start;
    in_bus.y_start   <= it.cmd.y_start;
    in_bus.x_end     <= it.cmd.x_end;
    in_bus.y_end     <= it.cmd.y_end;
    in_bus.pen_size  <= it.cmd.pen_size;
    in_bus.pen_color <= it.cmd.pen_color;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    items_sent++;
    if (it.op == OP_START) starts_sent++;
    idle_allowed = (items_sent < QuietFrom) && (items_sent % 200 < 150);
  endtask

  task automatic send_and_predict(input raster_item_t it);
    tlr_pixel_t px;
    send_item(it);
    if (next_pen_pixel(it, px)) pending_pixels.push_back(px);
  endtask

  // Holds the sender off until every pending pixel has come out.
  task automatic drain_pixels();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  function automatic raster_item_t random_step();
    raster_item_t it;
    it.cmd = 40'({$urandom(), $urandom()});
    it.op  = OP_STEP;
    return it;
  endfunction

  function automatic logic [7:0] pick_coord();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 127));
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 4)) : 8'($urandom_range(123, 127));
  endfunction

  function automatic logic [7:0] near_coord(input logic [7:0] base, input int reach);
    int v;
    v = int'(base) + $urandom_range(0, 2 * reach) - reach;
    if (v < 0) v = 0;
    if (v > 127) v = 127;
    return 8'(v);
  endfunction

  // A start item on the display, mostly small pens and short lines.
  function automatic raster_item_t random_line(output bit big_pen);
    raster_item_t it;
    int r, reach;
    r = $urandom_range(0, 99);
    big_pen = 1'b0;
    if (r < 3) begin
      it.cmd.pen_size = 4'd0;
      reach = 5;
    end else if (r < 50) begin
      it.cmd.pen_size = 4'd1;
      reach = 6;
    end else if (r < 78) begin
      it.cmd.pen_size = 4'd2;
      reach = 4;
    end else if (r < 93) begin
      it.cmd.pen_size = 4'($urandom_range(3, 4));
      reach = 2;
    end else begin
      it.cmd.pen_size = 4'($urandom_range(5, 15));
      reach = 0;
      big_pen = 1'b1;
    end
    it.op            = OP_START;
    it.cmd.pen_color = 4'($urandom_range(0, 15));
    it.cmd.x_start   = pick_coord();
    it.cmd.y_start   = pick_coord();
    it.cmd.x_end     = near_coord(it.cmd.x_start, reach);
    it.cmd.y_end     = near_coord(it.cmd.y_start, reach);
    return it;
  endfunction

  function automatic void add_row(input tlr_op_e op, input int xs, input int ys, input int xe,
                                  input int ye, input int sz, input int col,
                                  input row_check_e chk, input tlr_pixel_t pix);
    stim_row_t row;
    row.item.op            = op;
    row.item.cmd.x_start   = 8'(xs);
    row.item.cmd.y_start   = 8'(ys);
    row.item.cmd.x_end     = 8'(xe);
    row.item.cmd.y_end     = 8'(ye);
    row.item.cmd.pen_size  = 4'(sz);
    row.item.cmd.pen_color = 4'(col);
    row.check              = chk;
    row.pix                = pix;
    directed_rows.push_back(row);
  endfunction

  // Receiver stalls in random bursts.
  initial begin
    out_bus.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_allowed && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted pixel with the oldest expected one.
  always @(posedge clk_i) begin
    tlr_pixel_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      pixels_checked++;
      if (out_bus.last) lines_done++;
      if (pending_pixels.size() == 0) begin
        flag_error("pixel with nothing expected, x", out_bus.pixel_x, -1);
      end else begin
        want = pending_pixels.pop_front();
        if (out_bus.pixel_x !== want.x) flag_error("pixel_x", out_bus.pixel_x, want.x);
        if (out_bus.pixel_y !== want.y) flag_error("pixel_y", out_bus.pixel_y, want.y);
        if (out_bus.pixel_color !== want.color)
          flag_error("pixel_color", out_bus.pixel_color, want.color);
        if (out_bus.write_enable !== want.write_enable)
          flag_error("write_enable", out_bus.write_enable, want.write_enable);
        if (out_bus.last !== want.last) flag_error("last", out_bus.last, want.last);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycle_count,
               pending_pixels.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Main stimulus: reset, directed table, random line runs, drain.
  initial begin
    raster_item_t it;
    tlr_pixel_t   px;
    bit           got, big_pen;
    int           pick, cut, n;
    bit           paused_mid;

    in_bus.valid     <= 1'b0;
    in_bus.opcode    <= OP_STEP;
    in_bus.x_start   <= '0;
    in_bus.y_start   <= '0;
    in_bus.x_end     <= '0;
    in_bus.y_end     <= '0;
    in_bus.pen_size  <= '0;
    in_bus.pen_color <= '0;
    idle_allowed = 1'b1;
    paused_mid   = 1'b0;

    // Step after reset, single points at both corners, rejects, zero pen.
    add_row(OP_STEP,    0,   0,   0,   0,  0,  0, ROW_SILENT, '0);
    add_row(OP_START,   0,   0,   0,   0,  1, 15, ROW_SILENT, '0);
    add_row(OP_STEP,    0,   0,   0,   0,  0,  0, ROW_TYPED,  {8'hFF, 8'hFF, 4'hF, 1'b0, 1'b1});
    add_row(OP_START, 127, 127, 127, 127,  1,  0, ROW_SILENT, '0);
    add_row(OP_STEP,    0,   0,   0,   0,  0,  0, ROW_TYPED,  {8'd126, 8'd126, 4'h0, 1'b1, 1'b1});
    add_row(OP_START, 128,   0,   0,   0,  1,  1, ROW_SILENT, '0);
    add_row(OP_STEP,    0,   0,   0,   0,  0,  0, ROW_SILENT, '0);
    add_row(OP_START,   5,   5,   6,   6,  0,  3, ROW_SILENT, '0);
    add_row(OP_STEP,    0,   0,   0,   0,  0,  0, ROW_SILENT, '0);
    // A short thick line, then a start while busy that clips on the left.
    add_row(OP_START,  10,  20,  13,  18,  2,  5, ROW_PREDICT, '0);
    add_row(OP_STEP,  255, 255, 255, 255, 15, 15, ROW_PREDICT, '0);
    add_row(OP_STEP,    0,   0,   0,   0,  0,  0, ROW_PREDICT, '0);
    add_row(OP_START,   0,   5,   1,   5,  3,  9, ROW_PREDICT, '0);
    add_row(OP_STEP,    0,   0,   0,   0,  0,  0, ROW_PREDICT, '0);
    add_row(OP_STEP,    0,   0,   0,   0,  0,  0, ROW_PREDICT, '0);
    // Rejected starts while busy leave the line running.
    add_row(OP_START,   3, 128,   3,   3,  2,  4, ROW_SILENT, '0);
    add_row(OP_START,   3,   3, 255, 200,  2,  4, ROW_SILENT, '0);
    add_row(OP_STEP,    0,   0,   0,   0,  0,  0, ROW_PREDICT, '0);
    // Top clipping, display edge clipping, largest pen.
    add_row(OP_START,  20,   1,  20,   3,  2, 12, ROW_PREDICT, '0);
    add_row(OP_STEP,    0,   0,   0,   0,  0,  0, ROW_PREDICT, '0);
    add_row(OP_START, 126, 126, 127, 120,  4,  7, ROW_PREDICT, '0);
    add_row(OP_STEP,    0,   0,   0,   0,  0,  0, ROW_PREDICT, '0);
    add_row(OP_STEP,    0,   0,   0,   0,  0,  0, ROW_PREDICT, '0);
    add_row(OP_START, 127,   0, 127,   0, 15, 15, ROW_PREDICT, '0);
    add_row(OP_STEP,    0,   0,   0,   0,  0,  0, ROW_PREDICT, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item);
      got = next_pen_pixel(directed_rows[i].item, px);
      case (directed_rows[i].check)
        ROW_PREDICT: begin
          if (got) pending_pixels.push_back(px);
        end
        ROW_TYPED: begin
          pending_pixels.push_back(directed_rows[i].pix);
        end
        default: begin
        end
      endcase
    end

    drain_pixels();

    // Random part: mostly full lines stepped to their end, some cut short, some noise.
    while (items_sent < TotalItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        it = random_line(big_pen);
        send_and_predict(it);
        cut = (big_pen || $urandom_range(0, 11) == 0) ? $urandom_range(1, 60) : -1;
        n = 0;
        while (ln_busy && items_sent < TotalItems && n != cut) begin
          send_and_predict(random_step());
          n++;
        end
        repeat ($urandom_range(0, 2)) send_and_predict(random_step());
      end else if (pick < 93) begin
        it.op  = OP_START;
        it.cmd = 40'({$urandom(), $urandom()});
        send_and_predict(it);
      end else begin
        send_and_predict(random_step());
      end
      if (!paused_mid && items_sent >= TotalItems / 2) begin
        paused_mid = 1'b1;
        drain_pixels();
      end
    end

    in_bus.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_pixels.size() != 0)
      flag_error("pixels never produced", pending_pixels.size(), 0);

    $display("sent %0d items (%0d starts), checked %0d pixels, %0d lines ran to their end",
             items_sent, starts_sent, pixels_checked, lines_done);
    $display("covered rejects, zero pen, restarts, edge clipping and pen sizes 1 to 15");
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
